// ===== rtl/core/res_pkg.sv =====
// Package: widths, codes and request/result types for rectangle_edge_snap.
package res_pkg;
	localparam int MaxWindows = 64;
	localparam int IdxBits = 6;
	localparam int CoordBits = 20;
	localparam int WideBits = 24;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [WideBits-1:0] wide_t;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_MOVE   = 2'd1,
		OP_RESIZE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_STICK  = 3'd1;
	localparam logic [2:0] REG_LEFT   = 3'd2;
	localparam logic [2:0] REG_TOP    = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	// one stored window
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
	} win_t;

	// scan job handed to the scanner
	typedef struct packed {
		logic   is_move;
		logic [IdxBits-1:0] self_idx;
		logic [3:0] edges;
		wide_t  r0;
		wide_t  r1;
		wide_t  r2;
		wide_t  r3;
		wide_t  lim;
	} job_t;

	// per-axis best candidate
	typedef struct packed {
		logic  have;
		wide_t best;
	} cand_t;

	function automatic wide_t absw(wide_t v);
		return v[WideBits-1] ? -v : v;
	endfunction

	function automatic coord_t satc(wide_t v);
		if (v > wide_t'(2**(CoordBits-1) - 1))
			return coord_t'(2**(CoordBits-1) - 1);
		else if (v < -wide_t'(2**(CoordBits-1)))
			return coord_t'(-(2**(CoordBits-1)));
		else
			return coord_t'(v);
	endfunction

	// offer one edge to a running best
	function automatic cand_t offer(cand_t c, logic en, wide_t edge_v, wide_t target,
		wide_t lim);
		cand_t o;
		wide_t d;
		wide_t a;
		o = c;
		d = target - edge_v;
		a = absw(d);
		if (en && a <= lim && (!c.have || a < absw(c.best))) begin
			o.have = 1'b1;
			o.best = d;
		end
		return o;
	endfunction
endpackage

// ===== rtl/core/res_table.sv =====
// Window table: rectangle memory plus flag registers.
module res_table (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [res_pkg::IdxBits-1:0] wr_addr,
	input  res_pkg::win_t wr_data,
	input  logic wr_usable,
	input  logic wr_excluded,
	input  logic [res_pkg::IdxBits-1:0] rd_addr,
	output res_pkg::win_t rd_data,
	output logic rd_usable,
	output logic rd_excluded
);
	import res_pkg::*;

	win_t mem [MaxWindows];
	logic [MaxWindows-1:0] usable_q;
	logic [MaxWindows-1:0] excl_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '0;
			excl_q <= '0;
			rd_usable <= 1'b0;
			rd_excluded <= 1'b0;
		end else begin
			if (wr_en) begin
				usable_q[wr_addr] <= wr_usable;
				excl_q[wr_addr] <= wr_excluded;
			end
			rd_usable <= usable_q[rd_addr];
			rd_excluded <= excl_q[rd_addr];
		end
	end
endmodule

// ===== rtl/core/res_eval.sv =====
// Per-entry candidate evaluation for both axes.
module res_eval (
	input  res_pkg::job_t job,
	input  res_pkg::win_t win,
	input  res_pkg::cand_t cx_in,
	input  res_pkg::cand_t cy_in,
	output res_pkg::cand_t cx_out,
	output res_pkg::cand_t cy_out
);
	import res_pkg::*;

	wide_t ox0, oy0, ox1, oy1, ov, oh;
	logic el, er, et, eb;
	cand_t cx, cy;

	always_comb begin
		ox0 = wide_t'(win.x0);
		oy0 = wide_t'(win.y0);
		ox1 = wide_t'(win.x1);
		oy1 = wide_t'(win.y1);
		ov = ((job.r3 < oy1) ? job.r3 : oy1) - ((job.r1 > oy0) ? job.r1 : oy0);
		oh = ((job.r2 < ox1) ? job.r2 : ox1) - ((job.r0 > ox0) ? job.r0 : ox0);
		et = job.edges[0];
		eb = job.edges[1];
		el = job.edges[2];
		er = job.edges[3];
		cx = cx_in;
		cy = cy_in;
		if (ov > 0) begin
			cx = offer(cx, el, job.r0, ox1, job.lim);
			cx = offer(cx, er, job.r2, ox0, job.lim);
		end
		if (oh > 0) begin
			cy = offer(cy, et, job.r1, oy1, job.lim);
			cy = offer(cy, eb, job.r3, oy0, job.lim);
		end
		if (absw(ov) <= job.lim && oh > -job.lim) begin
			cx = offer(cx, el, job.r0, ox0, job.lim);
			cx = offer(cx, er, job.r2, ox1, job.lim);
		end
		if (absw(oh) <= job.lim && ov > -job.lim) begin
			cy = offer(cy, et, job.r1, oy0, job.lim);
			cy = offer(cy, eb, job.r3, oy1, job.lim);
		end
		cx_out = cx;
		cy_out = cy;
	end
endmodule

// ===== rtl/core/rectangle_edge_snap_top.sv =====
// Top level of rectangle_edge_snap: stream ports, APB registers, scan sequencer.
//
// Window edge snapping engine. A write request (operation 0) stores one window
// rectangle and its flags. A move or resize query first offers the work-area
// edges, then walks the 64-entry window table through one synchronous memory
// read port, one entry per cycle; after the walk its result passes a drain step
// for the read latency of the last entry and a pack step that forms the
// saturated result. One request is in flight at a time; the result sits in an
// output register, and the next request is not taken before the result is
// handed over. Flags reset to zero; rectangle contents are undefined until
// written. Registers: 0 enable, 1 stick distance, 2 area left, 3 area top,
// 4 area width, 5 area height.
module rectangle_edge_snap_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// op[1:0] idx[7:2] usable[8] excl[9] x[29:10] y[49:30] w[68:50] h[87:69]
	// edges[91:88] gw[111:92] gh[131:112] maximized[132], zero pad to 136
	input  logic [135:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// first[19:0] second[39:20] snap_h[40] snap_v[41], zero pad to 48
	output logic [47:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import res_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WRITE = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_PACK  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic en_q;
	logic [7:0] stick_q;
	logic signed [15:0] aleft_q, atop_q;
	logic [14:0] awidth_q, aheight_q;

	// request fields
	op_t op_in;
	logic [IdxBits-1:0] idx_in;
	coord_t x_in, y_in, gw_in, gh_in;
	logic [CoordBits-2:0] w_in, h_in;
	logic [3:0] edges_in;
	assign op_in = op_t'(s_tdata[1:0]);
	assign idx_in = s_tdata[7:2];
	assign x_in = s_tdata[29:10];
	assign y_in = s_tdata[49:30];
	assign w_in = s_tdata[68:50];
	assign h_in = s_tdata[87:69];
	assign edges_in = s_tdata[91:88];
	assign gw_in = s_tdata[111:92];
	assign gh_in = s_tdata[131:112];

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			stick_q <= 8'd10;
			aleft_q <= '0;
			atop_q <= '0;
			awidth_q <= 15'd1920;
			aheight_q <= 15'd1080;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_ENABLE: en_q <= pwdata[0];
				REG_STICK:  stick_q <= pwdata[7:0];
				REG_LEFT:   aleft_q <= pwdata[15:0];
				REG_TOP:    atop_q <= pwdata[15:0];
				REG_WIDTH:  awidth_q <= pwdata[14:0];
				REG_HEIGHT: aheight_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[4:2])
			REG_ENABLE: prdata = {31'd0, en_q};
			REG_STICK:  prdata = {24'd0, stick_q};
			REG_LEFT:   prdata = {{16{aleft_q[15]}}, aleft_q};
			REG_TOP:    prdata = {{16{atop_q[15]}}, atop_q};
			REG_WIDTH:  prdata = {17'd0, awidth_q};
			REG_HEIGHT: prdata = {17'd0, aheight_q};
			default:    prdata = '0;
		endcase
	end

	// captured request
	job_t job_q;
	logic on_q;
	coord_t x_q, y_q, gw_q, gh_q;
	win_t wdata_q;
	logic wusable_q, wexcl_q;
	logic [IdxBits-1:0] widx_q;
	cand_t cx_q, cy_q, cx_n, cy_n;
	logic [IdxBits:0] cnt_q;
	logic [IdxBits-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic [47:0] out_q;

	win_t rd_win;
	logic rd_use, rd_excl;
	logic take;
	assign s_tready = (state_q == ST_IDLE);
	assign take = s_tvalid && s_tready;

	res_table u_table (
		.clk(clk), .arst_n(arst_n),
		.wr_en(state_q == ST_WRITE), .wr_addr(widx_q), .wr_data(wdata_q),
		.wr_usable(wusable_q), .wr_excluded(wexcl_q),
		.rd_addr(cnt_q[IdxBits-1:0]), .rd_data(rd_win),
		.rd_usable(rd_use), .rd_excluded(rd_excl)
	);

	res_eval u_eval (
		.job(job_q), .win(rd_win), .cx_in(cx_q), .cy_in(cy_q),
		.cx_out(cx_n), .cy_out(cy_n)
	);

	// combinational setup of a query's reference box and area candidates
	wide_t r0, r1, r2, r3, dist_w, alw, arw, atw, abw;
	logic [3:0] eq;
	cand_t ax, ay;
	logic is_move, on_now;
	always_comb begin
		is_move = (op_in == OP_MOVE);
		on_now = en_q && (stick_q != 8'd0) && !(is_move && s_tdata[132]);
		r0 = wide_t'(x_in);
		r1 = wide_t'(y_in);
		r2 = wide_t'(x_in) + wide_t'({1'b0, w_in});
		r3 = wide_t'(y_in) + wide_t'({1'b0, h_in});
		eq = is_move ? 4'hf : edges_in;
		if (!is_move) begin
			if (edges_in[2]) r0 = r0 - wide_t'(gw_in);
			else if (edges_in[3]) r2 = r2 + wide_t'(gw_in);
			if (edges_in[0]) r1 = r1 - wide_t'(gh_in);
			else if (edges_in[1]) r3 = r3 + wide_t'(gh_in);
		end
		dist_w = wide_t'({stick_q, 4'd0});
		// area left/top are signed pixels: keep the sign through the scaling
		alw = wide_t'($signed({aleft_q, 4'd0}));
		arw = wide_t'($signed({aleft_q, 4'd0})) + wide_t'({awidth_q, 4'd0});
		atw = wide_t'($signed({atop_q, 4'd0}));
		abw = wide_t'($signed({atop_q, 4'd0})) + wide_t'({aheight_q, 4'd0});
		ax = '0;
		ay = '0;
		ax = offer(ax, eq[2], r0, alw, dist_w);
		ax = offer(ax, eq[3], r2, arw, dist_w);
		ay = offer(ay, eq[0], r1, atw, dist_w);
		ay = offer(ay, eq[1], r3, abw, dist_w);
	end

	// final result
	wide_t dx, dy, v1, v2;
	always_comb begin
		dx = cx_q.have ? cx_q.best : '0;
		dy = cy_q.have ? cy_q.best : '0;
		if (job_q.is_move) begin
			v1 = wide_t'(x_q) + dx;
			v2 = wide_t'(y_q) + dy;
		end else begin
			v1 = wide_t'(gw_q) + (job_q.edges[2] ? -dx : dx);
			v2 = wide_t'(gh_q) + (job_q.edges[0] ? -dy : dy);
		end
	end

	logic hit;
	assign hit = rd_vld_s1 && rd_use && (rd_idx_s1 != job_q.self_idx)
		&& !(job_q.is_move && rd_excl);

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= '{is_move: is_move, self_idx: idx_in, edges: eq,
				r0: r0, r1: r1, r2: r2, r3: r3, lim: dist_w};
			x_q <= x_in;
			y_q <= y_in;
			gw_q <= gw_in;
			gh_q <= gh_in;
			widx_q <= idx_in;
			wdata_q <= '{x0: x_in, y0: y_in,
				x1: satc(wide_t'(x_in) + wide_t'({1'b0, w_in})),
				y1: satc(wide_t'(y_in) + wide_t'({1'b0, h_in}))};
			wusable_q <= s_tdata[8];
			wexcl_q <= s_tdata[9];
			on_q <= on_now;
			cx_q <= on_now ? ax : '0;
			cy_q <= on_now ? ay : '0;
		end else if (hit && on_q) begin
			cx_q <= cx_n;
			cy_q <= cy_n;
		end
		rd_idx_s1 <= cnt_q[IdxBits-1:0];
		// last entry folds in during drain, so the result is formed in the pack state that follows
		if (state_q == ST_PACK)
			out_q <= {6'd0, dy != 0, dx != 0, satc(v2), satc(v1)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (take) begin
						priority case (op_in)
							OP_WRITE:  state_q <= ST_WRITE;
							OP_MOVE, OP_RESIZE: state_q <= ST_SCAN;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (IdxBits+1)'(MaxWindows - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_PACK;
				ST_PACK: state_q <= ST_OUT;
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = out_q;
endmodule

// ===== verif/res_checker.sv =====
// Checker for rectangle_edge_snap: watches requests and results, predicts and compares.
`timescale 1ns / 100ps
module res_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [135:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [47:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int fails,
	output int pending
);
	import res_pkg::*;

	localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
	localparam longint CoordMin = -CoordMax - 1;

	typedef struct {
		logic [19:0] first;
		logic [19:0] second;
		logic snap_h;
		logic snap_v;
	} snap_res_t;

	snap_res_t snap_q[$];

	// register copies
	bit snap_on_reg;
	longint stick_px, area_x, area_y, area_w, area_h;

	// window table copy
	longint win_x0[MaxWindows];
	longint win_y0[MaxWindows];
	longint win_x1[MaxWindows];
	longint win_y1[MaxWindows];
	bit win_usable[MaxWindows];
	bit win_excl[MaxWindows];

	assign pending = snap_q.size();

	function automatic longint clamp_coord(longint v);
		if (v > CoordMax) return CoordMax;
		if (v < CoordMin) return CoordMin;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void try_edge(longint edge_v, longint tgt, longint lim,
		inout longint best, inout bit have);
		longint d;
		d = tgt - edge_v;
		if (mag(d) <= lim && (!have || mag(d) < mag(best))) begin
			best = d;
			have = 1'b1;
		end
	endfunction

	function automatic void nearest_offsets(int self_i, bit skip_excl, longint r[4],
		logic [3:0] edg, output longint dx, output longint dy);
		longint lim, bx, by, ov, oh;
		bit hx, hy;
		lim = stick_px * 16;
		hx = 0; hy = 0; bx = 0; by = 0;
		if (edg[2]) try_edge(r[0], area_x * 16, lim, bx, hx);
		if (edg[3]) try_edge(r[2], (area_x + area_w) * 16, lim, bx, hx);
		if (edg[0]) try_edge(r[1], area_y * 16, lim, by, hy);
		if (edg[1]) try_edge(r[3], (area_y + area_h) * 16, lim, by, hy);
		for (int i = 0; i < MaxWindows; i++) begin
			if (i == self_i || !win_usable[i] || (skip_excl && win_excl[i]))
				continue;
			ov = ((r[3] < win_y1[i]) ? r[3] : win_y1[i]) - ((r[1] > win_y0[i]) ? r[1] : win_y0[i]);
			oh = ((r[2] < win_x1[i]) ? r[2] : win_x1[i]) - ((r[0] > win_x0[i]) ? r[0] : win_x0[i]);
			// side by side: opposite edges
			if (ov > 0) begin
				if (edg[2]) try_edge(r[0], win_x1[i], lim, bx, hx);
				if (edg[3]) try_edge(r[2], win_x0[i], lim, bx, hx);
			end
			if (oh > 0) begin
				if (edg[0]) try_edge(r[1], win_y1[i], lim, by, hy);
				if (edg[1]) try_edge(r[3], win_y0[i], lim, by, hy);
			end
			// stacked: same edges
			if (mag(ov) <= lim && oh > -lim) begin
				if (edg[2]) try_edge(r[0], win_x0[i], lim, bx, hx);
				if (edg[3]) try_edge(r[2], win_x1[i], lim, bx, hx);
			end
			if (mag(oh) <= lim && ov > -lim) begin
				if (edg[0]) try_edge(r[1], win_y0[i], lim, by, hy);
				if (edg[1]) try_edge(r[3], win_y1[i], lim, by, hy);
			end
		end
		dx = hx ? bx : 0;
		dy = hy ? by : 0;
	endfunction

	task automatic report(string what, logic [19:0] got, logic [19:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic take_request(logic [135:0] d);
		op_t op;
		int idx;
		longint x, y, w, h, gw, gh, dx, dy, v1, v2;
		longint r[4];
		logic [3:0] edg;
		bit on;
		snap_res_t e;
		op = op_t'(d[1:0]);
		idx = int'(d[7:2]);
		x = longint'($signed(d[29:10]));
		y = longint'($signed(d[49:30]));
		w = longint'(d[68:50]);
		h = longint'(d[87:69]);
		edg = d[91:88];
		gw = longint'($signed(d[111:92]));
		gh = longint'($signed(d[131:112]));
		on = snap_on_reg && stick_px != 0;
		dx = 0; dy = 0;
		r[0] = x; r[1] = y; r[2] = x + w; r[3] = y + h;
		case (op)
			OP_WRITE: begin
				win_x0[idx] = x;
				win_y0[idx] = y;
				win_x1[idx] = clamp_coord(x + w);
				win_y1[idx] = clamp_coord(y + h);
				win_usable[idx] = d[8];
				win_excl[idx] = d[9];
				return;
			end
			OP_NONE: return;
			OP_MOVE: begin
				if (on && !d[132])
					nearest_offsets(idx, 1'b1, r, 4'hf, dx, dy);
				v1 = clamp_coord(x + dx);
				v2 = clamp_coord(y + dy);
			end
			default: begin
				if (on) begin
					if (edg[2]) r[0] -= gw;
					else if (edg[3]) r[2] += gw;
					if (edg[0]) r[1] -= gh;
					else if (edg[1]) r[3] += gh;
					nearest_offsets(idx, 1'b0, r, edg, dx, dy);
				end
				v1 = clamp_coord(gw + (edg[2] ? -dx : dx));
				v2 = clamp_coord(gh + (edg[0] ? -dy : dy));
			end
		endcase
		e.first = v1[19:0];
		e.second = v2[19:0];
		e.snap_h = dx != 0;
		e.snap_v = dy != 0;
		snap_q.push_back(e);
	endtask

	initial begin
		fails = 0;
		snap_on_reg = 0;
		stick_px = 10;
		area_x = 0; area_y = 0; area_w = 1920; area_h = 1080;
		for (int i = 0; i < MaxWindows; i++) begin
			win_usable[i] = 0;
			win_excl[i] = 0;
		end
	end

	always @(posedge clk) begin
		snap_res_t e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ENABLE: snap_on_reg = pwdata[0];
					REG_STICK:  stick_px = longint'(pwdata[7:0]);
					REG_LEFT:   area_x = longint'($signed(pwdata[15:0]));
					REG_TOP:    area_y = longint'($signed(pwdata[15:0]));
					REG_WIDTH:  area_w = longint'(pwdata[14:0]);
					REG_HEIGHT: area_h = longint'(pwdata[14:0]);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (snap_q.size() == 0) begin
					$display("MISMATCH unexpected result %0h at %0t", m_tdata, $realtime);
					fails++;
				end else begin
					e = snap_q.pop_front();
					if (m_tdata[19:0] !== e.first) report("first_value", m_tdata[19:0], e.first);
					if (m_tdata[39:20] !== e.second)
						report("second_value", m_tdata[39:20], e.second);
					if (m_tdata[40] !== e.snap_h)
						report("snapped_h", 20'(m_tdata[40]), 20'(e.snap_h));
					if (m_tdata[41] !== e.snap_v)
						report("snapped_v", 20'(m_tdata[41]), 20'(e.snap_v));
				end
			end
			if (s_tvalid && s_tready)
				take_request(s_tdata);
		end
	end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top for rectangle_edge_snap: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
	import res_pkg::*;

	// one snap request, fields as they travel in s_tdata
	typedef struct {
		op_t op;
		logic [5:0] idx;
		logic usable;
		logic excl;
		logic [19:0] x;
		logic [19:0] y;
		logic [18:0] w;
		logic [18:0] h;
		logic [3:0] edges;
		logic [19:0] gw;
		logic [19:0] gh;
		logic maxed;
	} snap_req_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// op[1:0] idx[7:2] usable[8] excl[9] x[29:10] y[49:30] w[68:50] h[87:69]
	// edges[91:88] gw[111:92] gh[131:112] maximized[132], zero pad to 136
	logic [135:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// first[19:0] second[39:20] snap_h[40] snap_v[41], zero pad to 48
	logic [47:0] m_tdata;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fails;
	int pending;

	rectangle_edge_snap_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	res_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [135:0] pack_req(snap_req_t q);
		return {3'b0, q.maxed, q.gh, q.gw, q.edges, q.h, q.w, q.y, q.x,
			q.excl, q.usable, q.idx, q.op};
	endfunction

	// coordinate in Q15.4 from whole pixels plus a random fraction
	function automatic logic [19:0] px(int p);
		return 20'(p * 16 + $urandom_range(0, 15));
	endfunction

	// APB write: setup, then access
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// only reconfigure once the block has drained; writes leave no result, so
	// give a write request time to retire too
	task automatic set_cfg(bit en, int stick, int left, int top, int wd, int ht);
		wait (pending == 0);
		repeat (100) @(negedge clk);
		reg_write(REG_ENABLE, 32'(en));
		reg_write(REG_STICK, 32'(stick));
		reg_write(REG_LEFT, 32'(left));
		reg_write(REG_TOP, 32'(top));
		reg_write(REG_WIDTH, 32'(wd));
		reg_write(REG_HEIGHT, 32'(ht));
	endtask

	// offer one request with a random gap; valid stays high across back to
	// back requests so it is never dropped and raised in one step
	task automatic send(snap_req_t q);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pack_req(q);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_in();
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	function automatic snap_req_t blank(op_t op, int idx);
		snap_req_t q;
		q.op = op; q.idx = 6'(idx); q.usable = 1; q.excl = 0;
		q.x = 0; q.y = 0; q.w = 0; q.h = 0; q.edges = 0;
		q.gw = 0; q.gh = 0; q.maxed = 0;
		return q;
	endfunction

	function automatic snap_req_t rand_req();
		snap_req_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q.op = pick < 30 ? OP_WRITE : pick < 65 ? OP_MOVE : pick < 96 ? OP_RESIZE : OP_NONE;
		q.idx = 6'($urandom_range(0, 63));
		q.usable = $urandom_range(0, 3) != 0;
		q.excl = $urandom_range(0, 3) == 0;
		q.edges = 4'($urandom);
		q.maxed = $urandom_range(0, 7) == 0;
		if ($urandom_range(0, 9) == 0) begin
			// full range, so every field bit toggles
			q.x = 20'($urandom); q.y = 20'($urandom);
			q.w = 19'($urandom); q.h = 19'($urandom);
			q.gw = 20'($urandom); q.gh = 20'($urandom);
		end else begin
			// around the work area, where edges actually meet
			q.x = px($urandom_range(0, 2100) - 100);
			q.y = px($urandom_range(0, 1300) - 100);
			q.w = 19'(px($urandom_range(0, 700)));
			q.h = 19'(px($urandom_range(0, 500)));
			q.gw = px($urandom_range(0, 80) - 40);
			q.gh = px($urandom_range(0, 80) - 40);
		end
		return q;
	endfunction

	// receiver: random stalls, runs without stalls, and one long hold-off so
	// the single result register fills and input backs up
	initial begin
		int gap, taken;
		m_tready = 0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 120) gap = 600;
			else if ((taken / 40) % 3 == 2) gap = 0;
			else gap = $urandom_range(0, 6);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	initial begin
		snap_req_t q;
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// snapping off after reset: queries pass through
		q = blank(OP_WRITE, 1);
		q.x = px(100); q.y = px(100); q.w = 19'(px(200)); q.h = 19'(px(200));
		send(q);
		q = blank(OP_MOVE, 0); q.x = px(5); q.y = px(3); q.w = 19'(px(50)); q.h = 19'(px(50));
		send(q);
		q = blank(OP_RESIZE, 0); q.x = px(5); q.edges = 4'hf; q.gw = px(7); q.gh = px(-7);
		send(q);
		idle_in();

		set_cfg(1, 10, 0, 0, 1920, 1080);
		// a small layout: plain, excluded, hidden
		q = blank(OP_WRITE, 2);
		q.x = 20'(300 * 16); q.y = 20'(100 * 16); q.w = 19'(200 * 16); q.h = 19'(200 * 16);
		send(q);
		q.idx = 3; q.excl = 1; q.x = 20'(300 * 16); q.y = 20'(310 * 16);
		send(q);
		q.idx = 4; q.excl = 0; q.usable = 0; q.x = 20'(600 * 16);
		send(q);
		// near work-area corner
		q = blank(OP_MOVE, 0); q.x = px(4); q.y = px(7); q.w = 19'(px(50)); q.h = 19'(px(50));
		send(q);
		// next to entry 2, then as entry 2 itself
		q = blank(OP_MOVE, 0); q.x = px(505); q.y = px(150); q.w = 19'(px(80));
		q.h = 19'(px(80));
		send(q);
		q.idx = 2;
		send(q);
		// beside excluded entry 3
		q.idx = 0; q.y = px(330);
		send(q);
		q.maxed = 1;
		send(q);
		// resize each edge alone, then all of them
		for (int e = 0; e < 5; e++) begin
			q = blank(OP_RESIZE, 0); q.x = px(510); q.y = px(120);
			q.w = 19'(px(100)); q.h = 19'(px(100));
			q.edges = e < 4 ? 4'(1 << e) : 4'hf;
			q.gw = px(3); q.gh = px(-3);
			send(q);
		end
		q.op = OP_NONE;
		send(q);
		// extremes: saturating stored edges and outputs
		q = blank(OP_WRITE, 5);
		q.x = 20'h7ffff; q.y = 20'h7ffff; q.w = 19'h7ffff; q.h = 19'h7ffff; q.excl = 1;
		send(q);
		q = blank(OP_MOVE, 6);
		q.x = 20'h7ffff; q.y = 20'h80000; q.w = 19'h7ffff; q.h = 19'h7ffff;
		send(q);
		q = blank(OP_RESIZE, 6);
		q.x = 20'h80000; q.y = 20'h7ffff; q.w = 19'h7ffff; q.h = 19'h7ffff;
		q.edges = 4'b1010; q.gw = 20'h7ffff; q.gh = 20'h80000;
		send(q);
		idle_in();

		// random phases under varied settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_cfg(1, 10, 0, 0, 1920, 1080);
				1: set_cfg(1, 255, -32768, 32767, 32767, 0);
				2: set_cfg(1, 0, 20, 10, 1800, 1000);
				3: set_cfg(0, 40, 0, 0, 1920, 1080);
				default: set_cfg(1, $urandom_range(1, 60), $urandom_range(0, 60) - 30,
					$urandom_range(0, 60) - 30, $urandom_range(1500, 2000),
					$urandom_range(900, 1200));
			endcase
			for (int n = 0; n < 100; n++)
				send(rand_req());
			idle_in();
		end

		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
